### rtl/core/m2x2ad_pkg.sv
// Shared types, constants and helper functions of the masked 2x2 average downsampler.
`default_nettype none
package m2x2ad_pkg;

  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned COLS_W      = 12;
  localparam int unsigned ROWS_W      = 13;
  localparam int unsigned ROW_CNT_W   = 12;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned ENTRY_W     = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_CELL_COLS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CELL_ROWS = 1'b1;

  localparam logic [COLS_W-1:0] CELL_COLS_RESET = 12'd1200;
  localparam logic [ROWS_W-1:0] CELL_ROWS_RESET = 13'd1200;
  localparam logic [ROWS_W-1:0] MAX_CELL_ROWS   = 13'd4096;

  localparam logic [PIXEL_W-1:0] VALID_MAX  = 8'd100;
  localparam logic [PIXEL_W-1:0] FILL_CODE  = 8'd253;
  localparam logic [PIXEL_W-1:0] WATER_CODE = 8'd0;

  // line entry: invalid sum mod 10 (13:10), valid count (9:8), valid sum (7:0)
  typedef struct packed {
    logic [3:0] modsum;
    logic [1:0] cnt;
    logic [7:0] sum;
  } entry_t;

  typedef enum logic [3:0] {
    ST_UPPER_LEFT  = 4'b0001,
    ST_UPPER_RIGHT = 4'b0010,
    ST_LOWER_LEFT  = 4'b0100,
    ST_LOWER_RIGHT = 4'b1000
  } state_t;

  typedef struct packed {
    logic acc_load;
    logic line_write;
    logic line_read;
    logic res_load;
    logic row_end;
    logic frame_end;
  } cmd_t;

  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    prod = {8'd0, v} * 16'd205;
    q    = prod[15:11];
    r    = v - {q, 3'b000} - {2'b00, q, 1'b0};
    return r[3:0];
  endfunction

  function automatic logic [3:0] addmod10(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[3:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/m2x2ad_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module m2x2ad_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [ADDR_W-1:0]        raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/m2x2ad_ctrl.sv
// Controller: pixel phase state machine, column and row counters, handshake.
`default_nettype none
module m2x2ad_ctrl #(
  parameter int unsigned MAX_CELL_COLS = 2048,
  parameter int unsigned COL_W         = 11
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [m2x2ad_pkg::COLS_W-1:0]  cell_cols,
  input  wire logic [m2x2ad_pkg::ROWS_W-1:0]  cell_rows,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [COL_W-1:0]               col,
  output m2x2ad_pkg::cmd_t                    cmd
);

  localparam int unsigned CW = ((COL_W > m2x2ad_pkg::COLS_W) ? COL_W : m2x2ad_pkg::COLS_W) + 1;

  m2x2ad_pkg::state_t state, state_next;
  logic [COL_W-1:0]                    pixel_column;
  logic [m2x2ad_pkg::ROW_CNT_W-1:0]    cell_row;
  logic [CW-1:0]                       last_col;
  logic [m2x2ad_pkg::ROWS_W-1:0]       last_row;
  logic                                accept;
  logic                                at_row_end;
  logic                                at_last_row;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign col      = pixel_column;

  always_comb begin
    if (cell_cols == '0) begin
      last_col = '0;
    end else if (CW'(cell_cols) > CW'(MAX_CELL_COLS)) begin
      last_col = CW'(MAX_CELL_COLS - 1);
    end else begin
      last_col = CW'(cell_cols) - CW'(1);
    end
    if (cell_rows == '0) begin
      last_row = '0;
    end else if (cell_rows > m2x2ad_pkg::MAX_CELL_ROWS) begin
      last_row = m2x2ad_pkg::MAX_CELL_ROWS - 13'd1;
    end else begin
      last_row = cell_rows - 13'd1;
    end
  end

  assign at_row_end  = CW'(pixel_column) >= last_col;
  assign at_last_row = {1'b0, cell_row} >= last_row;

  always_comb begin
    state_next = state;
    case (state)
      m2x2ad_pkg::ST_UPPER_LEFT:  state_next = m2x2ad_pkg::ST_UPPER_RIGHT;
      m2x2ad_pkg::ST_UPPER_RIGHT: state_next = at_row_end ? m2x2ad_pkg::ST_LOWER_LEFT
                                                          : m2x2ad_pkg::ST_UPPER_LEFT;
      m2x2ad_pkg::ST_LOWER_LEFT:  state_next = m2x2ad_pkg::ST_LOWER_RIGHT;
      m2x2ad_pkg::ST_LOWER_RIGHT: state_next = at_row_end ? m2x2ad_pkg::ST_UPPER_LEFT
                                                          : m2x2ad_pkg::ST_LOWER_LEFT;
      default:                    state_next = m2x2ad_pkg::ST_UPPER_LEFT;
    endcase
  end

  always_comb begin
    cmd.acc_load   = accept && (state == m2x2ad_pkg::ST_UPPER_LEFT ||
                                state == m2x2ad_pkg::ST_LOWER_LEFT);
    cmd.line_write = accept && (state == m2x2ad_pkg::ST_UPPER_RIGHT);
    cmd.line_read  = accept && (state == m2x2ad_pkg::ST_LOWER_LEFT);
    cmd.res_load   = accept && (state == m2x2ad_pkg::ST_LOWER_RIGHT);
    cmd.row_end    = at_row_end;
    cmd.frame_end  = at_row_end && at_last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= m2x2ad_pkg::ST_UPPER_LEFT;
      pixel_column <= '0;
      cell_row     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (cmd.line_write || cmd.res_load) begin
        pixel_column <= at_row_end ? '0 : pixel_column + COL_W'(1);
      end
      if (cmd.res_load && at_row_end) begin
        cell_row <= at_last_row ? '0 : cell_row + 12'd1;
      end
      if (cmd.res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/m2x2ad_datapath.sv
// Datapath: pixel masking, pair accumulator, line buffer and cell average.
`default_nettype none
module m2x2ad_datapath #(
  parameter int unsigned MAX_CELL_COLS = 2048,
  parameter int unsigned COL_W         = 11
) (
  input  wire logic                            clk,
  input  wire logic [m2x2ad_pkg::PIXEL_W-1:0]  pixel_value,
  input  wire logic [COL_W-1:0]                col,
  input  wire m2x2ad_pkg::cmd_t                cmd,
  output logic      [m2x2ad_pkg::PIXEL_W-1:0]  cell_value,
  output logic                                 row_end,
  output logic                                 frame_end
);

  m2x2ad_pkg::entry_t pix, pair_acc, pair, upper;
  logic [8:0]  ts;
  logic [2:0]  tc;
  logic [3:0]  tm;
  logic [9:0]  n3;
  logic [19:0] prod3;
  logic [8:0]  half;
  logic [8:0]  quarter;
  logic [7:0]  value;

  always_comb begin
    if (pixel_value <= m2x2ad_pkg::VALID_MAX) begin
      pix.sum    = pixel_value;
      pix.cnt    = 2'd1;
      pix.modsum = 4'd0;
    end else begin
      pix.sum    = 8'd0;
      pix.cnt    = 2'd0;
      pix.modsum = m2x2ad_pkg::mod10(pixel_value);
    end
    pair.sum    = pair_acc.sum + pix.sum;
    pair.cnt    = pair_acc.cnt + pix.cnt;
    pair.modsum = m2x2ad_pkg::addmod10(pair_acc.modsum, pix.modsum);
  end

  m2x2ad_ram #(
    .WIDTH (m2x2ad_pkg::ENTRY_W),
    .DEPTH (MAX_CELL_COLS)
  ) u_line (
    .clk   (clk),
    .we    (cmd.line_write),
    .waddr (col),
    .wdata (pair),
    .re    (cmd.line_read),
    .raddr (col),
    .rdata (upper)
  );

  always_comb begin
    ts      = {1'b0, upper.sum} + {1'b0, pair.sum};
    tc      = {1'b0, upper.cnt} + {1'b0, pair.cnt};
    tm      = m2x2ad_pkg::addmod10(upper.modsum, pair.modsum);
    n3      = {ts, 1'b0} + 10'd3;
    prod3   = {10'd0, n3} * 20'd683;
    half    = ts + 9'd1;
    quarter = ts + 9'd2;
    case (tc)
      3'd1:    value = ts[7:0];
      3'd2:    value = half[8:1];
      3'd3:    value = prod3[19:12];
      3'd4:    value = {1'b0, quarter[8:2]};
      default: value = (tm != 4'd0) ? m2x2ad_pkg::FILL_CODE : m2x2ad_pkg::WATER_CODE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      pair_acc <= pix;
    end
    if (cmd.res_load) begin
      cell_value <= value;
      row_end    <= cmd.row_end;
      frame_end  <= cmd.frame_end;
    end
  end

endmodule
`default_nettype wire

### rtl/core/masked_2x2_average_downsampler.sv
// Top level of the masked 2x2 average downsampler: configuration registers and core.
//
// Takes raster pixels in row-major order, one per beat, and emits one beat per 2x2 cell:
// the rounded-half-up mean of the pixels of 100 or less, or 253 (fill) / 0 (water) when
// none is valid. A beat is accepted every clock while the output register is empty or
// drained in the same cycle; the result is registered as the lower-right pixel of its
// cell is accepted. The line buffer is written on upper-row pair ends and read one
// pixel ahead of each lower-row pair end, so its single read and write ports never
// limit the rate. Its contents are undefined after reset and need no clearing pass.
// m_tlast marks the last cell of an output row and m_tuser the last cell of the frame.
// Write cell_cols (index 0) and cell_rows (index 1) only while the block is idle.
`default_nettype none
module masked_2x2_average_downsampler #(
  parameter int unsigned MAX_CELL_COLS = 2048
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [m2x2ad_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [m2x2ad_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [7:0]                          s_tdata,   // pixel_value[7:0]
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [7:0]                          m_tdata,   // cell_value[7:0]
  output logic                                     m_tlast,   // row_end
  output logic                                     m_tuser    // frame_end
);

  localparam int unsigned COL_W = (MAX_CELL_COLS > 1) ? $clog2(MAX_CELL_COLS) : 1;

  logic [m2x2ad_pkg::COLS_W-1:0] cell_cols;
  logic [m2x2ad_pkg::ROWS_W-1:0] cell_rows;
  logic [COL_W-1:0]              col;
  m2x2ad_pkg::cmd_t              cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_cols <= m2x2ad_pkg::CELL_COLS_RESET;
      cell_rows <= m2x2ad_pkg::CELL_ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        m2x2ad_pkg::REG_CELL_COLS: cell_cols <= cfg_wdata[m2x2ad_pkg::COLS_W-1:0];
        m2x2ad_pkg::REG_CELL_ROWS: cell_rows <= cfg_wdata[m2x2ad_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  m2x2ad_ctrl #(
    .MAX_CELL_COLS (MAX_CELL_COLS),
    .COL_W         (COL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cell_cols (cell_cols),
    .cell_rows (cell_rows),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .col       (col),
    .cmd       (cmd)
  );

  m2x2ad_datapath #(
    .MAX_CELL_COLS (MAX_CELL_COLS),
    .COL_W         (COL_W)
  ) u_datapath (
    .clk         (clk),
    .pixel_value (s_tdata),
    .col         (col),
    .cmd         (cmd),
    .cell_value  (m_tdata),
    .row_end     (m_tlast),
    .frame_end   (m_tuser)
  );

endmodule
`default_nettype wire

### rtl/core/m2x2ad_checker.sv
// Port-level checker for the masked 2x2 average downsampler, bound to the top level.
`default_nettype none
module m2x2ad_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [7:0]                          m_tdata,
  input wire logic                                m_tlast,
  input wire logic                                m_tuser
);

  a_out_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end without row end");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result register is full");

endmodule

bind masked_2x2_average_downsampler m2x2ad_checker u_checker (.*);
`default_nettype wire
